// ===== rtl/core/rrts_pkg.sv =====
// Shared types, codes and sizes of the round robin task scheduler.
package rrts_pkg;

	localparam int NumSlots = 64;
	localparam int IdWidth  = 16;

	typedef enum logic [2:0] {
		FN_CREATE   = 3'd0,
		FN_DISPATCH = 3'd1,
		FN_COMPLETE = 3'd2,
		FN_BLOCK    = 3'd3,
		FN_WAKE     = 3'd4,
		FN_QUERY    = 3'd5
	} func_e_t;

	typedef enum logic [1:0] {
		ST_FINISHED = 2'd0,
		ST_READY    = 2'd1,
		ST_RUNNING  = 2'd2,
		ST_BLOCKED  = 2'd3
	} status_t;

	localparam logic [1:0] OC_FINISHED = 2'd0;
	localparam logic [1:0] OC_BLOCKED  = 2'd1;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_SCAN,
		SQ_RESP
	} seq_state_t;

	// one task request
	typedef struct packed {
		logic [2:0]          func;
		logic [31:0]         entry_handle;
		logic [31:0]         context_handle;
		logic [15:0]         target_id;
		logic [1:0]          outcome;
	} req_t;

	// one result
	typedef struct packed {
		logic                accepted;
		logic [15:0]         result_id;
		logic [31:0]         entry_out;
		logic [31:0]         context_out;
		logic [1:0]          result_state;
		logic [15:0]         active_id;
		logic [6:0]          live_tasks;
		logic [6:0]          ready_tasks;
	} rsp_t;

	// id and status of one slot
	typedef struct packed {
		logic [IdWidth-1:0]  id;
		status_t             status;
	} meta_t;

	// memory command group
	typedef struct packed {
		logic                rd_en;
		logic                wr_en;
		logic                wr_handles;
	} mem_cmd_t;

endpackage

// ===== rtl/core/rrts_slot_mem.sv =====
// Slot table: id/status memory with per-slot valid bits and a handle memory.
module rrts_slot_mem import rrts_pkg::*; #(
	parameter int NUM_SLOTS = NumSlots,
	localparam int IDX_W = $clog2(NUM_SLOTS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mem_cmd_t         cmd,
	input  logic [IDX_W-1:0] rd_addr,
	input  logic [IDX_W-1:0] wr_addr,
	input  meta_t            wr_meta,
	input  logic [31:0]      wr_entry,
	input  logic [31:0]      wr_context,
	output meta_t            rd_meta,
	output logic [31:0]      rd_entry,
	output logic [31:0]      rd_context
);

	meta_t              meta_mem [NUM_SLOTS];
	logic [63:0]        hdl_mem  [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] valid_q;
	meta_t              meta_rd_q;
	logic [63:0]        hdl_rd_q;

	// mark slots written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// write and read the id/status memory
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			meta_mem[wr_addr] <= wr_meta;
		end
		if (cmd.rd_en) begin
			meta_rd_q <= valid_q[rd_addr] ? meta_mem[rd_addr] : '0;
		end
	end

	// write and read the handle memory
	always_ff @(posedge clk) begin
		if (cmd.wr_en && cmd.wr_handles) begin
			hdl_mem[wr_addr] <= {wr_entry, wr_context};
		end
		if (cmd.rd_en) begin
			hdl_rd_q <= hdl_mem[rd_addr];
		end
	end

	assign rd_meta    = meta_rd_q;
	assign rd_entry   = hdl_rd_q[63:32];
	assign rd_context = hdl_rd_q[31:0];

endmodule

// ===== rtl/core/rrts_ctrl.sv =====
// Request sequencer: slot scans, read-modify-write of the table, counters.
module rrts_ctrl import rrts_pkg::*; #(
	parameter int NUM_SLOTS = NumSlots,
	localparam int IDX_W = $clog2(NUM_SLOTS),
	localparam int CNT_W = $clog2(NUM_SLOTS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output mem_cmd_t         mem_cmd,
	output logic [IDX_W-1:0] mem_rd_addr,
	output logic [IDX_W-1:0] mem_wr_addr,
	output meta_t            mem_wr_meta,
	output logic [31:0]      mem_wr_entry,
	output logic [31:0]      mem_wr_context,
	input  meta_t            mem_rd_meta,
	input  logic [31:0]      mem_rd_entry,
	input  logic [31:0]      mem_rd_context,
	output logic             res_valid,
	input  logic             res_take,
	output rsp_t             res
);

	localparam logic [IDX_W-1:0] LastIdx = IDX_W'(NUM_SLOTS - 1);
	localparam logic [CNT_W-1:0] FullCnt = CNT_W'(NUM_SLOTS);

	seq_state_t        state_q, state_d;
	func_e_t           op_q;
	req_t              cmd_q;
	logic [IDX_W-1:0]  scan_idx_q, rd_idx_s1, run_idx_q, cursor_q;
	logic [CNT_W-1:0]  issued_q, checked_q, lim_q, live_q, ready_q;
	logic              rd_vld_s1;
	logic [IdWidth-1:0] nid_q, run_id_q, nid_use;
	rsp_t              res_q, res_d;
	logic [CNT_W+6:0]  live_w, ready_w;

	logic              accept, fail, issue, hit, chk, found, last, done;
	logic              live_new, live_old, rdy_new, rdy_old;
	logic [IDX_W-1:0]  start_idx, idx_inc;
	logic [CNT_W-1:0]  start_lim;

	assign accept  = (state_q == SQ_IDLE) && req_valid;
	assign nid_use = (nid_q == '0) ? IdWidth'(1) : nid_q;
	assign idx_inc = (scan_idx_q == LastIdx) ? '0 : scan_idx_q + 1'b1;

	// check the request before any scan
	always_comb begin
		fail      = 1'b0;
		start_idx = '0;
		start_lim = FullCnt;
		unique case (req.func)
			FN_CREATE:   fail = (req.entry_handle == '0);
			FN_DISPATCH: begin
				fail      = (run_id_q != '0);
				start_idx = cursor_q;
			end
			FN_COMPLETE: begin
				fail      = (run_id_q == '0);
				start_idx = run_idx_q;
				start_lim = CNT_W'(1);
			end
			FN_BLOCK, FN_WAKE, FN_QUERY: fail = (req.target_id == '0);
			default:     fail = 1'b1;
		endcase
	end

	// match the slot that came back from the memory
	always_comb begin
		unique case (op_q)
			FN_CREATE:   hit = (mem_rd_meta.id == '0);
			FN_DISPATCH: hit = (mem_rd_meta.status == ST_READY);
			FN_COMPLETE: hit = 1'b1;
			default:     hit = (mem_rd_meta.id == cmd_q.target_id);
		endcase
	end

	assign issue = (state_q == SQ_SCAN) && (issued_q < lim_q);
	assign chk   = (state_q == SQ_SCAN) && rd_vld_s1;
	assign found = chk && hit;
	assign last  = chk && (checked_q == lim_q - 1'b1);
	assign done  = found || last;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE: if (req_valid) begin
				state_d = fail ? SQ_RESP : SQ_SCAN;
			end
			SQ_SCAN: if (done) begin
				state_d = SQ_RESP;
			end
			SQ_RESP: if (res_take) begin
				state_d = SQ_IDLE;
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	// memory command and result of a found slot
	always_comb begin
		mem_cmd        = '0;
		mem_cmd.rd_en  = issue;
		mem_rd_addr    = scan_idx_q;
		mem_wr_addr    = rd_idx_s1;
		mem_wr_meta    = mem_rd_meta;
		mem_wr_entry   = cmd_q.entry_handle;
		mem_wr_context = cmd_q.context_handle;
		res_d          = '0;
		if (found) begin
			unique case (op_q)
				FN_CREATE: begin
					mem_cmd.wr_en      = 1'b1;
					mem_cmd.wr_handles = 1'b1;
					mem_wr_meta        = '{id: nid_use, status: ST_READY};
					res_d.accepted     = 1'b1;
					res_d.result_id    = 16'(nid_use);
				end
				FN_DISPATCH: begin
					mem_cmd.wr_en      = 1'b1;
					mem_wr_meta.status = ST_RUNNING;
					res_d.accepted     = 1'b1;
					res_d.result_id    = 16'(mem_rd_meta.id);
					res_d.entry_out    = mem_rd_entry;
					res_d.context_out  = mem_rd_context;
				end
				FN_COMPLETE: begin
					mem_cmd.wr_en  = 1'b1;
					res_d.accepted = 1'b1;
					priority if (cmd_q.outcome == OC_FINISHED) begin
						mem_wr_meta = '0;
					end else if (cmd_q.outcome == OC_BLOCKED) begin
						mem_wr_meta = '{id: run_id_q, status: ST_BLOCKED};
					end else begin
						mem_wr_meta = '{id: run_id_q, status: ST_READY};
					end
				end
				FN_BLOCK: if (mem_rd_meta.status != ST_FINISHED) begin
					mem_cmd.wr_en      = 1'b1;
					mem_wr_meta.status = ST_BLOCKED;
					res_d.accepted     = 1'b1;
				end
				FN_WAKE: if (mem_rd_meta.status == ST_BLOCKED) begin
					mem_cmd.wr_en      = 1'b1;
					mem_wr_meta.status = ST_READY;
					res_d.accepted     = 1'b1;
				end
				default: begin
					res_d.accepted     = 1'b1;
					res_d.result_state = mem_rd_meta.status;
				end
			endcase
		end
	end

	assign live_new = (mem_wr_meta.id != '0);
	assign live_old = (mem_rd_meta.id != '0);
	assign rdy_new  = (mem_wr_meta.status == ST_READY);
	assign rdy_old  = (mem_rd_meta.status == ST_READY);

	// sequencer and scheduler registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SQ_IDLE;
			op_q      <= FN_CREATE;
			issued_q  <= '0;
			checked_q <= '0;
			lim_q     <= '0;
			scan_idx_q <= '0;
			rd_idx_s1 <= '0;
			rd_vld_s1 <= 1'b0;
			nid_q     <= IdWidth'(1);
			run_id_q  <= '0;
			run_idx_q <= '0;
			cursor_q  <= '0;
			live_q    <= '0;
			ready_q   <= '0;
		end else begin
			state_q <= state_d;
			// start a scan
			if (accept && !fail) begin
				op_q       <= func_e_t'(req.func);
				scan_idx_q <= start_idx;
				lim_q      <= start_lim;
				issued_q   <= '0;
				checked_q  <= '0;
			end
			// advance the scan
			if (issue) begin
				scan_idx_q <= idx_inc;
				issued_q   <= issued_q + 1'b1;
			end
			if (chk) begin
				checked_q <= checked_q + 1'b1;
			end
			rd_idx_s1 <= scan_idx_q;
			rd_vld_s1 <= issue && !done;
			// update counts on a table write
			if (mem_cmd.wr_en) begin
				live_q  <= live_q + CNT_W'(live_new) - CNT_W'(live_old);
				ready_q <= ready_q + CNT_W'(rdy_new) - CNT_W'(rdy_old);
			end
			// update the running task and id counter
			if (found && op_q == FN_CREATE) begin
				nid_q <= nid_use + 1'b1;
			end
			if (found && op_q == FN_DISPATCH) begin
				run_id_q  <= mem_rd_meta.id;
				run_idx_q <= rd_idx_s1;
				cursor_q  <= (rd_idx_s1 == LastIdx) ? '0 : rd_idx_s1 + 1'b1;
			end
			if (found && op_q == FN_COMPLETE) begin
				run_id_q <= '0;
			end
		end
	end

	// hold the request and the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req;
			res_q <= '0;
		end
		if (chk && done) begin
			res_q <= res_d;
		end
	end

	assign live_w  = {7'd0, live_q};
	assign ready_w = {7'd0, ready_q};

	// drive the result
	always_comb begin
		res             = res_q;
		res.active_id   = 16'(run_id_q);
		res.live_tasks  = live_w[6:0];
		res.ready_tasks = ready_w[6:0];
	end

	assign res_valid = (state_q == SQ_RESP);
	assign req_stall = (state_q != SQ_IDLE);

endmodule

// ===== rtl/core/round_robin_task_scheduler.sv =====
// Top level of the round robin task scheduler with its output register.
//
// Requests enter on task_req under req_valid/req_stall; results leave on
// task_rsp under rsp_valid/rsp_stall, one result for every request.
// The scheduler works on one request at a time; req_stall is high from the
// cycle after a request is taken until its result is loaded into the output
// register.
// A request that needs no slot search (unknown function, null entry,
// id 0, dispatch while running, complete with nothing running) goes
// straight to its result. Complete reads one slot. Create, dispatch,
// block, wake and query walk the slot memory one slot a cycle through
// its single read port and read at most NUM_SLOTS slots.
// Reset clears all slots through per-slot valid bits at once; no clearing
// pass runs and the block takes a request in the first cycle after reset.
// While the receiver stalls, the result holds in the output register; the
// next request is still taken and worked on, and its result waits until the
// register frees.
module round_robin_task_scheduler import rrts_pkg::*; #(
	parameter int NUM_SLOTS = NumSlots,
	localparam int IDX_W = $clog2(NUM_SLOTS)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t task_req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t task_rsp
);

	mem_cmd_t         mem_cmd;
	logic [IDX_W-1:0] mem_rd_addr, mem_wr_addr;
	meta_t            mem_wr_meta, mem_rd_meta;
	logic [31:0]      mem_wr_entry, mem_wr_context, mem_rd_entry, mem_rd_context;
	logic             res_valid, res_take;
	rsp_t             res;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	rrts_slot_mem #(.NUM_SLOTS(NUM_SLOTS)) u_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (mem_cmd),
		.rd_addr    (mem_rd_addr),
		.wr_addr    (mem_wr_addr),
		.wr_meta    (mem_wr_meta),
		.wr_entry   (mem_wr_entry),
		.wr_context (mem_wr_context),
		.rd_meta    (mem_rd_meta),
		.rd_entry   (mem_rd_entry),
		.rd_context (mem_rd_context)
	);

	rrts_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req            (task_req),
		.mem_cmd        (mem_cmd),
		.mem_rd_addr    (mem_rd_addr),
		.mem_wr_addr    (mem_wr_addr),
		.mem_wr_meta    (mem_wr_meta),
		.mem_wr_entry   (mem_wr_entry),
		.mem_wr_context (mem_wr_context),
		.mem_rd_meta    (mem_rd_meta),
		.mem_rd_entry   (mem_rd_entry),
		.mem_rd_context (mem_rd_context),
		.res_valid      (res_valid),
		.res_take       (res_take),
		.res            (res)
	);

	// load the output register when it is empty or being drained
	assign res_take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign task_rsp  = rsp_q;

endmodule

// ===== rtl/core/rrts_checker.sv =====
// Port-level checks of the round robin task scheduler and their bind.
module rrts_checker import rrts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t task_rsp
);

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(task_rsp))
		else $error("stalled result changed");

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

	// ready tasks are a subset of live tasks
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> task_rsp.ready_tasks <= task_rsp.live_tasks)
		else $error("ready count above live count");

	// a rejected request carries no id, handles or state
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !task_rsp.accepted |-> task_rsp.result_id == '0 &&
		task_rsp.entry_out == '0 && task_rsp.context_out == '0 &&
		task_rsp.result_state == '0)
		else $error("rejected request returned data");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.task_rsp  (task_rsp)
);

// ===== bench/tb_round_robin_task_scheduler.sv =====
// Self-checking testbench for the round robin task scheduler.
`timescale 1ns / 1ps

module tb_round_robin_task_scheduler;
	import rrts_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t task_req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t task_rsp;

	// scheduler state as predicted from the accepted requests
	logic [15:0] tbl_id [NumSlots];
	status_t     tbl_status [NumSlots];
	logic [31:0] tbl_entry [NumSlots];
	logic [31:0] tbl_ctx [NumSlots];
	logic [15:0] id_counter;
	logic [15:0] run_id;
	int          run_idx;
	int          cursor;

	rsp_t exp_rsp_q[$];
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   errors = 0;
	int   n_sent = 0;
	int   n_checked = 0;
	int   n_dispatched = 0;
	int   cycles = 0;
	int   hold_left = 0;
	bit   hold_req = 1'b0;

	round_robin_task_scheduler uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.task_req(task_req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.task_rsp(task_rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// count cycles and stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// drive the result stall: random, or a long hold when asked
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// compare each result with the oldest expected one
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (exp_rsp_q.size() == 0) begin
				$error("result with nothing expected: %h", task_rsp);
				errors++;
			end else begin
				e = exp_rsp_q.pop_front();
				n_checked++;
				if (task_rsp.accepted !== e.accepted) begin
					$error("accepted exp %0d got %0d", e.accepted, task_rsp.accepted);
					errors++;
				end
				if (task_rsp.result_id !== e.result_id) begin
					$error("result_id exp %0d got %0d", e.result_id, task_rsp.result_id);
					errors++;
				end
				if (task_rsp.entry_out !== e.entry_out) begin
					$error("entry_out exp %h got %h", e.entry_out, task_rsp.entry_out);
					errors++;
				end
				if (task_rsp.context_out !== e.context_out) begin
					$error("context_out exp %h got %h", e.context_out, task_rsp.context_out);
					errors++;
				end
				if (task_rsp.result_state !== e.result_state) begin
					$error("result_state exp %0d got %0d", e.result_state,
						task_rsp.result_state);
					errors++;
				end
				if (task_rsp.active_id !== e.active_id) begin
					$error("active_id exp %0d got %0d", e.active_id, task_rsp.active_id);
					errors++;
				end
				if (task_rsp.live_tasks !== e.live_tasks) begin
					$error("live_tasks exp %0d got %0d", e.live_tasks, task_rsp.live_tasks);
					errors++;
				end
				if (task_rsp.ready_tasks !== e.ready_tasks) begin
					$error("ready_tasks exp %0d got %0d", e.ready_tasks,
						task_rsp.ready_tasks);
					errors++;
				end
			end
		end
	end

	function automatic int find_slot(logic [15:0] id);
		int k;
		k = -1;
		if (id != 0)
			for (int i = NumSlots - 1; i >= 0; i--)
				if (tbl_id[i] == id) k = i;
		return k;
	endfunction

	// apply one request to the predicted table and build its result
	function automatic rsp_t sched_predict(req_t r);
		rsp_t o;
		int k;
		int idx;
		bit done;
		o = '0;
		done = 1'b0;
		case (r.func)
			FN_CREATE: begin
				if (r.entry_handle != 0)
					for (int i = 0; i < NumSlots; i++)
						if (!done && tbl_id[i] == 0) begin
							if (id_counter == 0) id_counter = 1;
							tbl_id[i] = id_counter;
							tbl_status[i] = ST_READY;
							tbl_entry[i] = r.entry_handle;
							tbl_ctx[i] = r.context_handle;
							id_counter = id_counter + 16'd1;
							o.accepted = 1'b1;
							o.result_id = tbl_id[i];
							done = 1'b1;
						end
			end
			FN_DISPATCH: begin
				if (run_id == 0)
					for (int i = 0; i < NumSlots; i++) begin
						idx = (cursor + i) % NumSlots;
						if (!done && tbl_id[idx] != 0 && tbl_status[idx] == ST_READY) begin
							cursor = (idx + 1) % NumSlots;
							run_id = tbl_id[idx];
							run_idx = idx;
							tbl_status[idx] = ST_RUNNING;
							o.accepted = 1'b1;
							o.result_id = tbl_id[idx];
							o.entry_out = tbl_entry[idx];
							o.context_out = tbl_ctx[idx];
							done = 1'b1;
						end
					end
			end
			FN_COMPLETE: begin
				if (run_id != 0) begin
					if (r.outcome == OC_FINISHED) begin
						tbl_id[run_idx] = 0;
						tbl_status[run_idx] = ST_FINISHED;
						tbl_entry[run_idx] = 0;
						tbl_ctx[run_idx] = 0;
					end else if (r.outcome == OC_BLOCKED) begin
						tbl_status[run_idx] = ST_BLOCKED;
					end else begin
						tbl_status[run_idx] = ST_READY;
					end
					run_id = 0;
					o.accepted = 1'b1;
				end
			end
			FN_BLOCK: begin
				k = find_slot(r.target_id);
				if (k >= 0 && tbl_status[k] != ST_FINISHED) begin
					tbl_status[k] = ST_BLOCKED;
					o.accepted = 1'b1;
				end
			end
			FN_WAKE: begin
				k = find_slot(r.target_id);
				if (k >= 0 && tbl_status[k] == ST_BLOCKED) begin
					tbl_status[k] = ST_READY;
					o.accepted = 1'b1;
				end
			end
			FN_QUERY: begin
				k = find_slot(r.target_id);
				if (k >= 0) begin
					o.accepted = 1'b1;
					o.result_state = tbl_status[k];
				end
			end
			default: ;
		endcase
		o.active_id = run_id;
		for (int i = 0; i < NumSlots; i++)
			if (tbl_id[i] != 0) begin
				o.live_tasks++;
				if (tbl_status[i] == ST_READY) o.ready_tasks++;
			end
		return o;
	endfunction

	// offer one request, wait for it to be taken, record its result
	task automatic send_request(req_t r, bit may_idle = 1'b1);
		rsp_t e;
		if (may_idle && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_valid <= 1'b1;
		task_req <= r;
		do @(posedge clk); while (req_stall);
		e = sched_predict(r);
		if (r.func == FN_DISPATCH && e.accepted) n_dispatched++;
		exp_rsp_q.push_back(e);
		n_sent++;
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (exp_rsp_q.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	function automatic req_t make_req(logic [2:0] f, logic [31:0] ent = 32'h1,
			logic [31:0] ctx = 32'h0, logic [15:0] tid = 16'h0, logic [1:0] oc = 2'd0);
		req_t r;
		r.func = f;
		r.entry_handle = ent;
		r.context_handle = ctx;
		r.target_id = tid;
		r.outcome = oc;
		return r;
	endfunction

	// random request, mostly aimed at live tasks
	function automatic req_t rand_request();
		req_t r;
		int w;
		int k;
		r.entry_handle = ($urandom_range(15) == 0) ? 32'h0 : $urandom;
		r.context_handle = $urandom;
		r.outcome = 2'($urandom_range(3));
		w = $urandom_range(99);
		if (w < 24) r.func = FN_CREATE;
		else if (w < 44) r.func = FN_DISPATCH;
		else if (w < 64) r.func = FN_COMPLETE;
		else if (w < 75) r.func = FN_BLOCK;
		else if (w < 86) r.func = FN_WAKE;
		else if (w < 97) r.func = FN_QUERY;
		else r.func = 3'($urandom_range(6, 7));
		w = $urandom_range(99);
		if (w < 75) begin
			k = $urandom_range(NumSlots - 1);
			for (int i = 0; i < NumSlots; i++)
				if (tbl_id[(k + i) % NumSlots] != 0 && tbl_id[k] == 0) k = (k + i) % NumSlots;
			r.target_id = (tbl_id[k] != 0) ? tbl_id[k] : run_id;
		end else if (w < 80) begin
			r.target_id = 16'h0;
		end else begin
			r.target_id = 16'($urandom);
		end
		return r;
	endfunction

	task automatic test_directed_ops();
		send_request(make_req(FN_DISPATCH));
		send_request(make_req(FN_COMPLETE, 32'h1, 32'h0, 16'h0, 2'd2));
		send_request(make_req(FN_BLOCK, 32'h1, 32'h0, 16'h0));
		send_request(make_req(FN_WAKE, 32'h1, 32'h0, 16'h5));
		send_request(make_req(FN_QUERY, 32'h1, 32'h0, 16'hffff));
		send_request(make_req(FN_CREATE, 32'h0, 32'hffffffff));
		send_request(make_req(FN_CREATE, 32'hffffffff, 32'hffffffff));
		send_request(make_req(FN_CREATE, 32'h1, 32'h0));
		send_request(make_req(FN_CREATE, 32'h80000000, 32'h5a5a5a5a));
		send_request(make_req(FN_DISPATCH));
		send_request(make_req(FN_DISPATCH));
		send_request(make_req(FN_QUERY, 32'h1, 32'h0, 16'd1));
		send_request(make_req(FN_BLOCK, 32'h1, 32'h0, 16'd1));
		send_request(make_req(FN_BLOCK, 32'h1, 32'h0, 16'd1));
		send_request(make_req(FN_QUERY, 32'h1, 32'h0, 16'd1));
		send_request(make_req(FN_COMPLETE, 32'h1, 32'h0, 16'h0, 2'd2));
		send_request(make_req(FN_WAKE, 32'h1, 32'h0, 16'd2));
		send_request(make_req(FN_DISPATCH));
		send_request(make_req(FN_COMPLETE, 32'h1, 32'h0, 16'h0, OC_BLOCKED));
		send_request(make_req(FN_WAKE, 32'h1, 32'h0, 16'd2));
		send_request(make_req(FN_DISPATCH));
		send_request(make_req(FN_COMPLETE, 32'h1, 32'h0, 16'h0, 2'd3));
		send_request(make_req(FN_DISPATCH));
		send_request(make_req(FN_COMPLETE, 32'h1, 32'h0, 16'h0, OC_FINISHED));
		send_request(make_req(3'd6, 32'h1, 32'h0, 16'd1));
		send_request(make_req(3'd7, 32'hffffffff, 32'hffffffff, 16'hffff, 2'd3));
	endtask

	// fill every slot, try one more, then finish one task and create again
	task automatic test_full_table();
		for (int i = 0; i < NumSlots + 1; i++)
			send_request(make_req(FN_CREATE, $urandom | 32'h1, $urandom));
		send_request(make_req(FN_DISPATCH));
		send_request(make_req(FN_COMPLETE, 32'h1, 32'h0, 16'h0, OC_FINISHED));
		send_request(make_req(FN_CREATE, $urandom | 32'h1, $urandom));
	endtask

	task automatic test_random(int n, int spct, int rpct);
		send_idle_pct = spct;
		recv_idle_pct = rpct;
		for (int i = 0; i < n; i++) send_request(rand_request());
		wait_drained();
	endtask

	// hold off results until the block backs up into its input
	task automatic test_receiver_hold();
		send_idle_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 24; i++) send_request(rand_request(), 1'b0);
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < NumSlots; i++) begin
			tbl_id[i] = 0;
			tbl_status[i] = ST_FINISHED;
			tbl_entry[i] = 0;
			tbl_ctx[i] = 0;
		end
		id_counter = 16'd1;
		run_id = 0;
		run_idx = 0;
		cursor = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		wait_drained();
		test_full_table();
		wait_drained();
		test_random(400, 36, 52);
		test_receiver_hold();
		test_random(400, 52, 36);
		test_random(400, 0, 0);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d dispatches), checked %0d results.",
			n_sent, n_dispatched, n_checked);
		$display("Covered all functions, full table, rejects and result back-pressure.");
		if (errors == 0 && exp_rsp_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
